### hdl/um32_pkg.sv
// Shared types and constants of the UM-32 register ALU execute block.
package um32_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned RegFieldW = 3;
  localparam int unsigned NumRegsDefault = 8;
  localparam int unsigned InDataW   = 56;
  localparam int unsigned OutDataW  = 40;
  localparam int unsigned OutUserW  = 4;
  localparam logic [DataW-1:0] ByteMax = DataW'(255);

  typedef enum logic [2:0] {
    CmdCmov  = 3'd0,
    CmdAdd   = 3'd1,
    CmdMul   = 3'd2,
    CmdDiv   = 3'd3,
    CmdNand  = 3'd4,
    CmdLoadi = 3'd5,
    CmdOut   = 3'd6,
    CmdIn    = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StDivZero  = 2'd1,
    StOutRange = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SIdle = 2'd0,
    SExec = 2'd1,
    SMdu  = 2'd2,
    SDone = 2'd3
  } state_e;

  // Start request to the multiply/divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } mdu_req_t;

endpackage

### hdl/um32_register_alu_execute_top.sv
// Top level of the UM-32 register ALU execute block.
//
// Channel  | Dir | tdata (low bit up)                          | tuser (low bit up)
// ---------+-----+---------------------------------------------+------------------------------
// s_axis   | in  | cmd[2:0] reg_a[5:3] reg_b[8:6] reg_c[11:9]  | in_eof[0]
//          |     | imm_value[43:12] in_byte[51:44], pad to 56  |
// m_axis   | out | out_byte[7:0] written_value[39:8]           | status[1:0] out_valid[2]
//          |     |                                             | wrote_reg[3]
//
// One instruction is in flight at a time. After an accepted transaction the block
// reads both source registers through its registered read ports, executes, then
// commits the register write and the result. Multiply and divide by a non-zero value
// wait for the 32-step iterative multiply/divide unit. Reset clears all registers
// to zero at once through per-entry valid bits, so no clearing pass is needed. A full
// output register stalls the commit; the result register holds until m_axis_tready.
module um32_register_alu_execute_top #(
  parameter int unsigned NumRegs = um32_pkg::NumRegsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [um32_pkg::InDataW-1:0]  s_axis_tdata,  // cmd, reg_a, reg_b, reg_c, imm, in_byte
  input  logic                          s_axis_tuser,  // in_eof
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [um32_pkg::OutDataW-1:0] m_axis_tdata,  // out_byte, written_value
  output logic [um32_pkg::OutUserW-1:0] m_axis_tuser   // status, out_valid, wrote_reg
);
  import um32_pkg::*;

  localparam int unsigned IdxW = $clog2(NumRegs);

  // Field positions inside s_axis_tdata
  localparam int unsigned CmdLsb  = 0;
  localparam int unsigned RegALsb = CmdLsb + 3;
  localparam int unsigned RegBLsb = RegALsb + RegFieldW;
  localparam int unsigned RegCLsb = RegBLsb + RegFieldW;
  localparam int unsigned ImmLsb  = RegCLsb + RegFieldW;
  localparam int unsigned InBLsb  = ImmLsb + DataW;

  state_e state_q, state_d;

  // Latched instruction fields
  cmd_e            cmd_q;
  logic [IdxW-1:0] ra_q, rc_q;
  logic [DataW-1:0] imm_q;
  logic [ByteW-1:0] inb_q;
  logic            eof_q;

  // Pending result
  status_e          res_status_q, res_status_d;
  logic             res_emit_q, res_emit_d;
  logic [ByteW-1:0] res_byte_q, res_byte_d;
  logic             res_write_q, res_write_d;
  logic [DataW-1:0] res_val_q, res_val_d;
  logic [IdxW-1:0]  res_dest_q, res_dest_d;
  logic             res_load;

  // Output register
  logic                out_full_q, out_full_d;
  logic [OutDataW-1:0] out_data_q;
  logic [OutUserW-1:0] out_user_q;

  logic             accept;
  logic             commit;
  logic [DataW-1:0] vb, vc;
  mdu_req_t         mdu_req;
  logic             mdu_done;
  logic [DataW-1:0] mdu_result;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign commit = (state_q == SDone) && (!out_full_q || m_axis_tready);

  // Read both sources straight from the incoming transaction
  um32_rf #(
    .NumRegs(NumRegs)
  ) u_rf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_b_addr_i (s_axis_tdata[RegBLsb +: IdxW]),
    .rd_c_addr_i (s_axis_tdata[RegCLsb +: IdxW]),
    .rd_b_data_o (vb),
    .rd_c_data_o (vc),
    .wr_en_i     (commit && res_write_q),
    .wr_addr_i   (res_dest_q),
    .wr_data_i   (res_val_q)
  );

  um32_mdu u_mdu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mdu_req),
    .op_a_i   (vb),
    .op_b_i   (vc),
    .done_o   (mdu_done),
    .result_o (mdu_result)
  );

  // Next state, execute and result selection
  always_comb begin
    state_d        = state_q;
    s_axis_tready  = 1'b0;
    mdu_req.start  = 1'b0;
    mdu_req.is_div = (cmd_q == CmdDiv);
    res_load       = 1'b0;
    res_status_d   = StOk;
    res_emit_d     = 1'b0;
    res_byte_d     = '0;
    res_write_d    = 1'b0;
    res_val_d      = '0;
    res_dest_d     = ra_q;
    unique case (state_q)
      SIdle: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = SExec;
        end
      end
      SExec: begin
        res_load = 1'b1;
        state_d  = SDone;
        unique case (cmd_q)
          CmdCmov: begin
            res_write_d = (vc != '0);
            res_val_d   = (vc != '0) ? vb : '0;
          end
          CmdAdd: begin
            res_write_d = 1'b1;
            res_val_d   = vb + vc;
          end
          CmdMul: begin
            res_write_d   = 1'b1;
            mdu_req.start = 1'b1;
            state_d       = SMdu;
          end
          CmdDiv: begin
            if (vc == '0) begin
              res_status_d = StDivZero;
            end else begin
              res_write_d   = 1'b1;
              mdu_req.start = 1'b1;
              state_d       = SMdu;
            end
          end
          CmdNand: begin
            res_write_d = 1'b1;
            res_val_d   = ~(vb & vc);
          end
          CmdLoadi: begin
            res_write_d = 1'b1;
            res_val_d   = imm_q;
          end
          CmdOut: begin
            if (vc > ByteMax) begin
              res_status_d = StOutRange;
            end else begin
              res_emit_d = 1'b1;
              res_byte_d = vc[ByteW-1:0];
            end
          end
          CmdIn: begin
            res_write_d = 1'b1;
            res_dest_d  = rc_q;
            res_val_d   = eof_q ? '1 : {{(DataW-ByteW){1'b0}}, inb_q};
          end
          default: begin
            state_d = SDone;
          end
        endcase
      end
      SMdu: begin
        // Hold everything but the value until the unit finishes
        res_status_d = res_status_q;
        res_emit_d   = res_emit_q;
        res_byte_d   = res_byte_q;
        res_write_d  = res_write_q;
        res_val_d    = mdu_result;
        res_dest_d   = res_dest_q;
        if (mdu_done) begin
          res_load = 1'b1;
          state_d  = SDone;
        end
      end
      SDone: begin
        if (commit) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_comb begin
    out_full_d = out_full_q;
    if (commit) begin
      out_full_d = 1'b1;
    end else if (m_axis_tready) begin
      out_full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      out_full_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      out_full_q <= out_full_d;
    end
  end

  // Capture the instruction on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_e'(s_axis_tdata[CmdLsb +: 3]);
      ra_q  <= s_axis_tdata[RegALsb +: IdxW];
      rc_q  <= s_axis_tdata[RegCLsb +: IdxW];
      imm_q <= s_axis_tdata[ImmLsb +: DataW];
      inb_q <= s_axis_tdata[InBLsb +: ByteW];
      eof_q <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_status_q <= res_status_d;
      res_emit_q   <= res_emit_d;
      res_byte_q   <= res_byte_d;
      res_write_q  <= res_write_d;
      res_val_q    <= res_val_d;
      res_dest_q   <= res_dest_d;
    end
  end

  // Load the output register on commit; a value not written reads as zero
  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_data_q <= {(res_write_q ? res_val_q : {DataW{1'b0}}), res_byte_q};
      out_user_q <= {res_write_q, res_emit_q, res_status_q};
    end
  end

  assign m_axis_tvalid = out_full_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // One instruction at a time: no second accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("input accepted while an instruction is in flight");

  // A byte output never writes a register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[2] && m_axis_tuser[3]))
    else $error("result both emits a byte and writes a register");

  // An error status never comes with a register write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[1:0] != StOk) |-> !m_axis_tuser[3])
    else $error("error status with register write");

  // The multiply/divide unit only finishes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdu_done |-> (state_q == SMdu))
    else $error("multiply/divide done outside its wait state");

endmodule

### hdl/um32_rf.sv
// Register file: one write port, two registered read ports, valid bits for reset-to-zero.
module um32_rf #(
  parameter int unsigned NumRegs = um32_pkg::NumRegsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [$clog2(NumRegs)-1:0]   rd_b_addr_i,
  input  logic [$clog2(NumRegs)-1:0]   rd_c_addr_i,
  output logic [um32_pkg::DataW-1:0]   rd_b_data_o,
  output logic [um32_pkg::DataW-1:0]   rd_c_data_o,
  input  logic                         wr_en_i,
  input  logic [$clog2(NumRegs)-1:0]   wr_addr_i,
  input  logic [um32_pkg::DataW-1:0]   wr_data_i
);
  import um32_pkg::*;

  logic [DataW-1:0]   mem [NumRegs];
  logic [NumRegs-1:0] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Entries never written read as zero
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_b_data_o <= valid_q[rd_b_addr_i] ? mem[rd_b_addr_i] : '0;
      rd_c_data_o <= valid_q[rd_c_addr_i] ? mem[rd_c_addr_i] : '0;
    end
  end

endmodule

### hdl/um32_mdu.sv
// Iterative 32-step multiply (low word) and restoring unsigned divide.
module um32_mdu (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  um32_pkg::mdu_req_t         req_i,
  input  logic [um32_pkg::DataW-1:0] op_a_i,
  input  logic [um32_pkg::DataW-1:0] op_b_i,
  output logic                       done_o,
  output logic [um32_pkg::DataW-1:0] result_o
);
  import um32_pkg::*;

  localparam int unsigned CntW = $clog2(DataW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic            is_div_q;
  logic [CntW-1:0] cnt_q;
  logic [DataW-1:0] acc_q, acc_d;
  logic [DataW-1:0] opa_q, opa_d;
  logic [DataW-1:0] opb_q, opb_d;
  logic [DataW+1:0] diff;

  always_comb begin
    diff  = {1'b0, acc_q, opa_q[DataW-1]} - {2'b00, opb_q};
    acc_d = acc_q;
    opa_d = opa_q;
    opb_d = opb_q;
    if (is_div_q) begin
      // Shift in one dividend bit, subtract when the divisor fits
      if (!diff[DataW+1]) begin
        acc_d = diff[DataW-1:0];
        opa_d = {opa_q[DataW-2:0], 1'b1};
      end else begin
        acc_d = {acc_q[DataW-2:0], opa_q[DataW-1]};
        opa_d = {opa_q[DataW-2:0], 1'b0};
      end
    end else begin
      acc_d = opb_q[0] ? acc_q + opa_q : acc_q;
      opa_d = {opa_q[DataW-2:0], 1'b0};
      opb_d = {1'b0, opb_q[DataW-1:1]};
    end
    busy_d = busy_q && (cnt_q != '0);
    done_d = busy_q && (cnt_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(DataW - 1);
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      is_div_q <= req_i.is_div;
      acc_q    <= '0;
      opa_q    <= op_a_i;
      opb_q    <= op_b_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      opa_q <= opa_d;
      opb_q <= opb_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = is_div_q ? opa_q : acc_q;

endmodule

### tb/tb_top.sv
// Self-checking testbench of the UM-32 register ALU execute block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import um32_pkg::*;

  localparam int unsigned RandomInstrs  = 450;
  localparam int unsigned QuietTail     = 40;    // last instructions sent with no idling
  localparam int unsigned DrainCycles   = 60;    // settle time after the last result
  localparam int unsigned WatchdogLimit = 2000;  // cycles with no transaction on either side

  // One decoded instruction plus a flag that holds it back until the block drains.
  typedef struct {
    cmd_e           cmd;
    logic [2:0]     reg_a;
    logic [2:0]     reg_b;
    logic [2:0]     reg_c;
    logic [DataW-1:0] imm;
    logic [ByteW-1:0] in_byte;
    logic           in_eof;
    bit             drain_first;
  } alu_instr_t;

  typedef struct {
    status_e          status;
    logic             out_valid;
    logic [ByteW-1:0] out_byte;
    logic             wrote_reg;
    logic [DataW-1:0] written_value;
  } alu_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;

  um32_register_alu_execute_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Instructions waiting to be sent, and results the register file model predicts.
  alu_instr_t  pending_instrs[$];
  alu_result_t expected_results[$];
  alu_instr_t  cur_instr;

  // Shadow copy of the architectural register file, zero after reset.
  logic [DataW-1:0] arch_regs [NumRegsDefault] = '{default: '0};

  int unsigned issued_count  = 0;
  int unsigned retired_count = 0;
  int unsigned fail_count    = 0;
  int unsigned quiet_cycles  = 0;
  bit          tail_phase    = 1'b0;

  // Driver and monitor bookkeeping, each owned by one process.
  bit src_accept;
  bit src_next_valid;
  int src_gap  = 0;
  int src_calm = 0;
  int sink_stall = 0;
  int sink_calm  = 0;
  alu_result_t want;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Compute the result of one instruction and commit its register write to the shadow copy.
  function automatic alu_result_t execute_instr(alu_instr_t ins);
    alu_result_t      res;
    logic [DataW-1:0] vb;
    logic [DataW-1:0] vc;
    logic [2:0]       dest;
    vb   = arch_regs[ins.reg_b];
    vc   = arch_regs[ins.reg_c];
    dest = ins.reg_a;
    res  = '{StOk, 1'b0, '0, 1'b0, '0};
    case (ins.cmd)
      CmdCmov: begin
        // zero condition leaves the destination alone
        if (vc != '0) begin
          res.wrote_reg     = 1'b1;
          res.written_value = vb;
        end
      end
      CmdAdd: begin
        res.wrote_reg     = 1'b1;
        res.written_value = vb + vc;
      end
      CmdMul: begin
        res.wrote_reg     = 1'b1;
        res.written_value = vb * vc;  // low word of the product
      end
      CmdDiv: begin
        if (vc == '0) begin
          res.status = StDivZero;
        end else begin
          res.wrote_reg     = 1'b1;
          res.written_value = vb / vc;
        end
      end
      CmdNand: begin
        res.wrote_reg     = 1'b1;
        res.written_value = ~(vb & vc);
      end
      CmdLoadi: begin
        res.wrote_reg     = 1'b1;
        res.written_value = ins.imm;
      end
      CmdOut: begin
        if (vc > ByteMax) begin
          res.status = StOutRange;
        end else begin
          res.out_valid = 1'b1;
          res.out_byte  = vc[ByteW-1:0];
        end
      end
      default: begin
        // input writes reg_c; end of input loads all ones and drops the byte
        dest              = ins.reg_c;
        res.wrote_reg     = 1'b1;
        res.written_value = ins.in_eof ? '1 : DataW'(ins.in_byte);
      end
    endcase
    if (res.wrote_reg) arch_regs[dest] = res.written_value;
    return res;
  endfunction

  task automatic queue_instr(input cmd_e cmd, input logic [2:0] ra, input logic [2:0] rb,
                             input logic [2:0] rc, input logic [DataW-1:0] imm,
                             input logic [ByteW-1:0] in_byte, input logic in_eof,
                             input bit drain_first);
    alu_instr_t ins;
    ins = '{cmd, ra, rb, rc, imm, in_byte, in_eof, drain_first};
    pending_instrs.push_back(ins);
  endtask

  task automatic check_field(input string field, input logic [DataW-1:0] exp_val,
                             input logic [DataW-1:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, exp_val,
               act_val);
      fail_count++;
    end
  endtask

  // Driver: present the next pending instruction, predict its result on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      src_accept = s_axis_tvalid && s_axis_tready;
      if (src_accept) begin
        expected_results.push_back(execute_instr(cur_instr));
        issued_count <= issued_count + 1;
      end
      if (src_calm > 0) src_calm--;
      // Hold tvalid and the data steady until the transaction completes.
      if (!s_axis_tvalid || src_accept) begin
        src_next_valid = 1'b0;
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_instrs.size() > 0) begin
          if (pending_instrs[0].drain_first &&
              (src_accept || issued_count != retired_count)) begin
            // hold off until every predicted result has been retired
          end else if (!tail_phase && src_calm == 0 && $urandom_range(0, 3) == 0) begin
            src_gap = $urandom_range(0, 16);
            if ($urandom_range(0, 2) == 0) src_calm = src_gap + $urandom_range(20, 80);
          end else begin
            cur_instr      = pending_instrs.pop_front();
            src_next_valid = 1'b1;
            s_axis_tdata   <= {4'b0, cur_instr.in_byte, cur_instr.imm, cur_instr.reg_c,
                               cur_instr.reg_b, cur_instr.reg_a, cur_instr.cmd};
            s_axis_tuser   <= cur_instr.in_eof;
          end
        end
        s_axis_tvalid <= src_next_valid;
      end
      tail_phase <= (pending_instrs.size() < QuietTail);
    end
  end

  // Monitor: check each result transaction against the oldest prediction, stall at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no instruction outstanding, expected none, actual %h/%h",
                   $time, m_axis_tuser, m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          retired_count <= retired_count + 1;
          check_field("status", DataW'(want.status), DataW'(m_axis_tuser[1:0]));
          check_field("out_valid", DataW'(want.out_valid), DataW'(m_axis_tuser[2]));
          check_field("wrote_reg", DataW'(want.wrote_reg), DataW'(m_axis_tuser[3]));
          check_field("out_byte", DataW'(want.out_byte), DataW'(m_axis_tdata[7:0]));
          check_field("written_value", want.written_value, m_axis_tdata[39:8]);
        end
      end
      if (sink_calm > 0) sink_calm--;
      if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else if (!tail_phase && sink_calm == 0 && $urandom_range(0, 4) == 0) begin
        sink_stall = $urandom_range(0, 16);
        if ($urandom_range(0, 2) == 0) sink_calm = sink_stall + $urandom_range(20, 80);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when neither side moves a transaction for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("tb_top failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int               pick;
    cmd_e             cmd_pick;
    logic [DataW-1:0] imm_pick;

    // Directed part: corner values, every command and each special case.
    queue_instr(CmdOut,   3'd0, 3'd0, 3'd0, 32'h0, 8'h00, 1'b0, 1'b0); // emit a zero byte
    queue_instr(CmdCmov,  3'd7, 3'd1, 3'd2, 32'h0, 8'h00, 1'b0, 1'b0); // zero condition
    queue_instr(CmdDiv,   3'd1, 3'd2, 3'd3, 32'h0, 8'h00, 1'b0, 1'b0); // divide by zero
    queue_instr(CmdLoadi, 3'd1, 3'd7, 3'd7, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b0);
    queue_instr(CmdLoadi, 3'd2, 3'd0, 3'd0, 32'h0000_0100, 8'h00, 1'b0, 1'b0);
    queue_instr(CmdOut,   3'd5, 3'd6, 3'd2, 32'h0, 8'h00, 1'b0, 1'b0); // 256 is out of range
    queue_instr(CmdLoadi, 3'd3, 3'd0, 3'd0, 32'h0000_00FF, 8'h00, 1'b0, 1'b0);
    queue_instr(CmdOut,   3'd0, 3'd0, 3'd3, 32'h0, 8'h00, 1'b0, 1'b0); // largest byte
    queue_instr(CmdAdd,   3'd4, 3'd1, 3'd1, 32'h0, 8'h00, 1'b0, 1'b0); // wraps
    queue_instr(CmdMul,   3'd5, 3'd1, 3'd1, 32'h0, 8'h00, 1'b0, 1'b0); // wraps to one
    queue_instr(CmdDiv,   3'd6, 3'd1, 3'd3, 32'h0, 8'h00, 1'b0, 1'b0);
    queue_instr(CmdNand,  3'd7, 3'd1, 3'd1, 32'h0, 8'h00, 1'b0, 1'b0);
    queue_instr(CmdCmov,  3'd0, 3'd1, 3'd3, 32'h0, 8'h00, 1'b0, 1'b0); // condition taken
    queue_instr(CmdIn,    3'd0, 3'd0, 3'd4, 32'h0, 8'hA5, 1'b1, 1'b0); // end of input
    queue_instr(CmdIn,    3'd1, 3'd2, 3'd5, 32'h0, 8'hFF, 1'b0, 1'b0);
    queue_instr(CmdIn,    3'd3, 3'd3, 3'd6, 32'h0, 8'h00, 1'b0, 1'b0);
    queue_instr(CmdDiv,   3'd7, 3'd3, 3'd1, 32'h0, 8'h00, 1'b0, 1'b0); // quotient zero
    queue_instr(CmdDiv,   3'd0, 3'd1, 3'd1, 32'h0, 8'h00, 1'b0, 1'b1); // after a full drain
    queue_instr(CmdMul,   3'd2, 3'd2, 3'd2, 32'h0, 8'h00, 1'b0, 1'b0);
    queue_instr(CmdLoadi, 3'd0, 3'd0, 3'd0, 32'h8000_0000, 8'h00, 1'b0, 1'b0);
    queue_instr(CmdNand,  3'd6, 3'd0, 3'd4, 32'h0, 8'h00, 1'b0, 1'b0);

    // Random part: favor small loads so division by zero and in-range output recur.
    for (int n = 0; n < RandomInstrs; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) cmd_pick = CmdLoadi;
      else if (pick < 32) cmd_pick = CmdOut;
      else cmd_pick = cmd_e'($urandom_range(0, 7));
      case ($urandom_range(0, 7))
        0:       imm_pick = '0;
        1:       imm_pick = '1;
        2:       imm_pick = 32'd1;
        3:       imm_pick = 32'h8000_0000;
        4, 5:    imm_pick = $urandom_range(0, 300);
        default: imm_pick = $urandom;
      endcase
      queue_instr(cmd_pick, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                  3'($urandom_range(0, 7)), imm_pick, 8'($urandom_range(0, 255)),
                  $urandom_range(0, 7) == 0, $urandom_range(0, 59) == 0);
    end

    // Hold reset, then release it once.
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every instruction has gone out and every result has been retired.
    do @(negedge clk_i);
    while (pending_instrs.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);

    if (expected_results.size() != 0) begin
      $display("%0t: results outstanding at end, expected 0, actual %0d", $time,
               expected_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
